### design/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// shared constants, status codes and the crc-8 byte step for the frame checker
// ----------------------------------------------------------------------------
package sfcc_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;

  // crc-8, msb first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // field widths
  localparam int unsigned RAW_W = 16;
  localparam int unsigned PQ_W  = 19;
  localparam int unsigned TQ_W  = 17;

  // scale factors
  localparam int unsigned SCALE_LOW  = 60;
  localparam int unsigned SCALE_HIGH = 240;
  localparam int unsigned SCALE_TEMP = 200;

  // raw*256/60 = (raw<<6)/15, raw*256/240 = (raw<<4)/15, raw*256/200 = (raw<<5)/25
  localparam int unsigned PRESS_DIV        = (SCALE_LOW * 64) / 256;
  localparam int unsigned PRESS_SHIFT_LOW  = 6;
  localparam int unsigned PRESS_SHIFT_HIGH = 4;
  localparam int unsigned TEMP_DIV         = (SCALE_TEMP * 32) / 256;
  localparam int unsigned TEMP_SHIFT       = 5;

  // numerator and quotient magnitude widths
  localparam int unsigned PN_W  = 22;
  localparam int unsigned TN_W  = 21;
  localparam int unsigned PQM_W = 18;
  localparam int unsigned TQM_W = 16;

  // reciprocal multiply, floor(2^S/d), exact to within one for these numerators
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] PRESS_RECIP = RECIP_W'((1 << RECIP_SHIFT) / PRESS_DIV);
  localparam logic [RECIP_W-1:0] TEMP_RECIP  = RECIP_W'((1 << RECIP_SHIFT) / TEMP_DIV);

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_LENGTH = 2'd1,
    STATUS_CRC    = 2'd2
  } frame_status_t;

  // one data byte through the crc, bit at a time
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### design/sfcc_if.sv
// ----------------------------------------------------------------------------
// sfcc channel interfaces
// valid/ready channels for received bytes, frame results and configuration
// ----------------------------------------------------------------------------
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface sfcc_out_if;
  import sfcc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] pressure_raw;
  logic signed [PQ_W-1:0]  pressure_q8;
  logic signed [RAW_W-1:0] temperature_raw;
  logic signed [TQ_W-1:0]  temperature_q8;
  logic [1:0]              frame_status;

  modport source (output valid, output pressure_raw, output pressure_q8,
                  output temperature_raw, output temperature_q8,
                  output frame_status, input ready);
  modport sink   (input valid, input pressure_raw, input pressure_q8,
                  input temperature_raw, input temperature_q8,
                  input frame_status, output ready);
endinterface

interface sfcc_cfg_if;
  logic valid;
  logic ready;
  logic pressure_range_select;

  modport source (output valid, output pressure_range_select, input ready);
  modport sink   (input valid, input pressure_range_select, output ready);
endinterface

### design/sensor_frame_crc_check_scale.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_scale
// checks a nine-byte sensor read frame and scales pressure and temperature
// ----------------------------------------------------------------------------
// Bytes of a read frame enter one per beat on in_ch, and the block takes a byte
// in every clock cycle in which in_ch.ready is high. The frame is three groups
// of two data bytes and a crc-8 byte (poly 0x31, init 0xff, msb first); each
// group is checked as it arrives. The beat with frame_end set closes the frame
// and yields one result beat on out_ch, registered in stage 1, stage 2 and the
// output register: raw pressure and temperature words, their Q8
// values (pressure raw*256/60 or raw*256/240 as cfg_ch selects, temperature
// raw*256/200, both truncated toward zero) and a status (good, length not
// nine, crc mismatch; length wins). A bad frame gives zero in all value
// fields. The rate of one byte per cycle is set by the combinational crc byte
// step in the frame register update; the scaling runs in a two-stage pipeline
// (reciprocal multiply, then remainder correction) ahead of the output
// register, and each stage moves on whenever the one after it has room, so a
// stalled result does not stop byte intake until all three result stages are
// full. Beats without frame_end produce no result. There is no clearing pass
// after reset. Write cfg_ch only while no frame result is in flight.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_scale (
  input  logic       clk,
  input  logic       rst_n,
  sfcc_in_if.sink    in_ch,
  sfcc_out_if.source out_ch,
  sfcc_cfg_if.sink   cfg_ch
);
  import sfcc_pkg::*;

  // configuration
  logic range_sel_r;

  // frame state
  logic [POS_W-1:0] byte_pos_r,   byte_pos_nxt;
  logic [7:0]       run_crc_r,    run_crc_nxt;
  logic [7:0]       held_byte_r,  held_byte_nxt;
  logic [RAW_W-1:0] first_word_r, first_word_nxt;
  logic [RAW_W-1:0] second_word_r, second_word_nxt;
  logic             crc_fail_r,   crc_fail_nxt;
  logic [POS_W-1:0] count;
  frame_status_t    status_nxt;

  // stage 1: closed frame
  logic                    s1_v_r;
  frame_status_t           s1_status_r;
  logic signed [RAW_W-1:0] s1_praw_r, s1_traw_r;
  logic                    s1_sel_r;

  // stage 2: first quotient estimate
  logic                    s2_v_r;
  frame_status_t           s2_status_r;
  logic signed [RAW_W-1:0] s2_praw_r, s2_traw_r;
  logic                    s2_pneg_r, s2_tneg_r;
  logic [PN_W-1:0]         s2_pnum_r;
  logic [TN_W-1:0]         s2_tnum_r;
  logic [PQM_W-1:0]        s2_pq0_r;
  logic [TQM_W-1:0]        s2_tq0_r;

  // output register
  logic                    out_v_r;
  frame_status_t           out_status_r;
  logic signed [RAW_W-1:0] out_praw_r, out_traw_r;
  logic signed [PQ_W-1:0]  out_pq_r;
  logic signed [TQ_W-1:0]  out_tq_r;

  // handshake
  logic acc, out_adv, s2_adv, s1_adv;

  assign out_adv     = out_ch.ready || !out_v_r;
  assign s2_adv      = !s2_v_r || out_adv;
  assign s1_adv      = !s1_v_r || s2_adv;
  assign in_ch.ready = s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  // --------------------------------------------------------------------------
  // frame tracking: crc per group, capture words, close on frame_end
  // --------------------------------------------------------------------------
  always_comb begin
    byte_pos_nxt    = byte_pos_r;
    run_crc_nxt     = run_crc_r;
    held_byte_nxt   = held_byte_r;
    first_word_nxt  = first_word_r;
    second_word_nxt = second_word_r;
    crc_fail_nxt    = crc_fail_r;
    count           = (byte_pos_r != {POS_W{1'b1}}) ? byte_pos_r + 1'b1 : byte_pos_r;
    status_nxt      = STATUS_OK;

    if (acc) begin
      if (byte_pos_r < POS_W'(FRAME_BYTES)) begin
        if (byte_pos_r inside {4'd0, 4'd3, 4'd6}) begin
          // high data byte of a group
          run_crc_nxt   = crc8_step(run_crc_r, in_ch.rx_byte);
          held_byte_nxt = in_ch.rx_byte;
        end else if (byte_pos_r inside {4'd1, 4'd4, 4'd7}) begin
          // low data byte; pressure word in group 0, temperature in group 1
          run_crc_nxt = crc8_step(run_crc_r, in_ch.rx_byte);
          if (byte_pos_r == 4'd1) begin
            first_word_nxt = {held_byte_r, in_ch.rx_byte};
          end
          if (byte_pos_r == 4'd4) begin
            second_word_nxt = {held_byte_r, in_ch.rx_byte};
          end
        end else begin
          // crc byte of a group
          if (run_crc_r != in_ch.rx_byte) begin
            crc_fail_nxt = 1'b1;
          end
          run_crc_nxt = CRC_INIT;
        end
      end
      byte_pos_nxt = count;

      if (in_ch.frame_end) begin
        if (count != POS_W'(FRAME_BYTES)) begin
          status_nxt = STATUS_LENGTH;
        end else if (crc_fail_nxt) begin
          status_nxt = STATUS_CRC;
        end
        // new frame starts clean
        byte_pos_nxt    = '0;
        run_crc_nxt     = CRC_INIT;
        held_byte_nxt   = '0;
        first_word_nxt  = '0;
        second_word_nxt = '0;
        crc_fail_nxt    = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 math: magnitude, scale shift, reciprocal multiply
  // --------------------------------------------------------------------------
  logic                      p_neg, t_neg;
  logic [RAW_W-1:0]          p_mag, t_mag;
  logic [PN_W-1:0]           p_num;
  logic [TN_W-1:0]           t_num;
  logic [PN_W+RECIP_W-1:0]   p_prod;
  logic [TN_W+RECIP_W-1:0]   t_prod;

  assign p_neg  = s1_praw_r[RAW_W-1];
  assign t_neg  = s1_traw_r[RAW_W-1];
  assign p_mag  = p_neg ? RAW_W'(-s1_praw_r) : RAW_W'(s1_praw_r);
  assign t_mag  = t_neg ? RAW_W'(-s1_traw_r) : RAW_W'(s1_traw_r);
  assign p_num  = s1_sel_r ? (PN_W'(p_mag) << PRESS_SHIFT_HIGH)
                           : (PN_W'(p_mag) << PRESS_SHIFT_LOW);
  assign t_num  = TN_W'(t_mag) << TEMP_SHIFT;
  assign p_prod = (PN_W+RECIP_W)'(p_num) * (PN_W+RECIP_W)'(PRESS_RECIP);
  assign t_prod = (TN_W+RECIP_W)'(t_num) * (TN_W+RECIP_W)'(TEMP_RECIP);

  // --------------------------------------------------------------------------
  // stage 2 math: remainder correction and sign
  // --------------------------------------------------------------------------
  logic [PN_W-1:0]  p_rem;
  logic [TN_W-1:0]  t_rem;
  logic [PQM_W-1:0] p_q;
  logic [TQM_W-1:0] t_q;
  logic [PQ_W-1:0]  p_ext, p_val;
  logic [TQ_W-1:0]  t_ext, t_val;

  assign p_rem = s2_pnum_r - PN_W'(s2_pq0_r) * PN_W'(PRESS_DIV);
  assign t_rem = s2_tnum_r - TN_W'(s2_tq0_r) * TN_W'(TEMP_DIV);
  assign p_q   = (p_rem >= PN_W'(PRESS_DIV)) ? s2_pq0_r + 1'b1 : s2_pq0_r;
  assign t_q   = (t_rem >= TN_W'(TEMP_DIV))  ? s2_tq0_r + 1'b1 : s2_tq0_r;
  assign p_ext = PQ_W'(p_q);
  assign t_ext = TQ_W'(t_q);
  assign p_val = s2_pneg_r ? (~p_ext + 1'b1) : p_ext;
  assign t_val = s2_tneg_r ? (~t_ext + 1'b1) : t_ext;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_sel_r   <= 1'b0;
      byte_pos_r    <= '0;
      run_crc_r     <= CRC_INIT;
      held_byte_r   <= '0;
      first_word_r  <= '0;
      second_word_r <= '0;
      crc_fail_r    <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        range_sel_r <= cfg_ch.pressure_range_select;
      end
      byte_pos_r    <= byte_pos_nxt;
      run_crc_r     <= run_crc_nxt;
      held_byte_r   <= held_byte_nxt;
      first_word_r  <= first_word_nxt;
      second_word_r <= second_word_nxt;
      crc_fail_r    <= crc_fail_nxt;
      if (s1_adv) begin
        s1_v_r <= acc && in_ch.frame_end;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (acc && in_ch.frame_end) begin
      s1_status_r <= status_nxt;
      s1_sel_r    <= range_sel_r;
      // good frame closes on its last crc byte, so both words are already held
      s1_praw_r   <= (status_nxt == STATUS_OK) ? $signed(first_word_r)  : '0;
      s1_traw_r   <= (status_nxt == STATUS_OK) ? $signed(second_word_r) : '0;
    end
    if (s2_adv && s1_v_r) begin
      s2_status_r <= s1_status_r;
      s2_praw_r   <= s1_praw_r;
      s2_traw_r   <= s1_traw_r;
      s2_pneg_r   <= p_neg;
      s2_tneg_r   <= t_neg;
      s2_pnum_r   <= p_num;
      s2_tnum_r   <= t_num;
      s2_pq0_r    <= p_prod[RECIP_SHIFT +: PQM_W];
      s2_tq0_r    <= t_prod[RECIP_SHIFT +: TQM_W];
    end
    if (out_adv && s2_v_r) begin
      out_status_r <= s2_status_r;
      out_praw_r   <= s2_praw_r;
      out_traw_r   <= s2_traw_r;
      out_pq_r     <= $signed(p_val);
      out_tq_r     <= $signed(t_val);
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.frame_status    = out_status_r;
  assign out_ch.pressure_raw    = out_praw_r;
  assign out_ch.pressure_q8     = out_pq_r;
  assign out_ch.temperature_raw = out_traw_r;
  assign out_ch.temperature_q8  = out_tq_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.frame_end) |=> (byte_pos_r == '0 && run_crc_r == CRC_INIT && !crc_fail_r))
    else $error("frame state not cleared after frame end");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_status_r != STATUS_OK) |-> (s1_praw_r == '0 && s1_traw_r == '0))
    else $error("bad frame carries nonzero words");

  a_quot_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (p_rem < PN_W'(2 * PRESS_DIV) && t_rem < TN_W'(2 * TEMP_DIV)))
    else $error("reciprocal estimate off by more than one");

  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_praw_r[RAW_W-1] || !out_pq_r[PQ_W-1])
              && (out_traw_r[RAW_W-1] || !out_tq_r[TQ_W-1])))
    else $error("scaled value sign disagrees with raw word");

endmodule
